// File: rtl/pmm_pkg.sv
// Shared types, codes and helpers of the payload mode manager.
`default_nettype none
package pmm_pkg;

	localparam logic EXPERIMENT_PRESENT = 1'b1;

	localparam logic [2:0] ACT_ENTER_REGION = 3'd0;
	localparam logic [2:0] ACT_LEAVE_REGION = 3'd1;
	localparam logic [2:0] ACT_EXP_FINISHED = 3'd2;
	localparam logic [2:0] ACT_MODE_REQUEST = 3'd3;
	localparam logic [2:0] ACT_ACTIVATE     = 3'd4;
	localparam logic [2:0] ACT_DEACTIVATE   = 3'd5;

	localparam logic [2:0] REQ_NORMAL    = 3'd0;
	localparam logic [2:0] REQ_HIBERNATE = 3'd1;
	localparam logic [2:0] REQ_STANDBY   = 3'd2;
	localparam logic [2:0] REQ_WAKE      = 3'd3;

	localparam logic [2:0] PL_COLLECTOR1 = 3'd0;
	localparam logic [2:0] PL_COLLECTOR2 = 3'd1;
	localparam logic [2:0] PL_EXPERIMENT = 3'd2;

	localparam logic [1:0] MODE_NORMAL      = 2'd0;
	localparam logic [1:0] MODE_HIBERNATION = 2'd1;
	localparam logic [1:0] MODE_STANDBY     = 2'd2;

	localparam logic [1:0] COL_NONE   = 2'd0;
	localparam logic [1:0] COL_FIRST  = 2'd1;
	localparam logic [1:0] COL_SECOND = 2'd2;

	localparam logic [1:0] EXP_CMD_NONE   = 2'd0;
	localparam logic [1:0] EXP_CMD_START  = 2'd1;
	localparam logic [1:0] EXP_CMD_CANCEL = 2'd2;

	localparam logic [1:0] RADIO_NONE    = 2'd0;
	localparam logic [1:0] RADIO_ENABLE  = 2'd1;
	localparam logic [1:0] RADIO_DISABLE = 2'd2;

	localparam logic [2:0] PWR_EXPERIMENT = 3'b100;

	localparam logic [0:0] REG_MAIN_COLLECTOR = 1'd0;
	localparam logic [0:0] REG_MANUAL_OVERRIDE = 1'd1;

	localparam logic [27:0] SECONDS_PER_HOUR = 28'd3600;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  argument;
		logic [15:0] hibernation_hours;
		logic        radio_enable_ok;
	} event_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        mode_changed;
		logic [1:0]  collector_slot;
		logic        collector_active;
		logic        experiment_active;
		logic [2:0]  power_on_mask;
		logic [2:0]  power_off_mask;
		logic [1:0]  experiment_command;
		logic [1:0]  radio_command;
		logic [27:0] duration_seconds;
		logic        error;
	} result_t;

	typedef struct packed {
		logic [1:0] current_mode;
		logic       hibernating;
		logic       in_region;
		logic [1:0] active_collector;
		logic       collector_on;
		logic       experiment_on;
	} state_t;

	typedef struct packed {
		logic [1:0] main_collector_select;
		logic       manual_override;
	} cfg_t;

	function automatic logic [2:0] slot_bit(input logic [1:0] slot);
		logic [2:0] bits;
		bits = 3'b000;
		if (slot == COL_FIRST) begin
			bits = 3'b001;
		end else if (slot == COL_SECOND) begin
			bits = 3'b010;
		end
		return bits;
	endfunction

endpackage
`default_nettype wire

// File: rtl/pmm_core.sv
// Event decoder: next state and result for one mission event.
`default_nettype none
module pmm_core (
	input  pmm_pkg::event_t  ev,
	input  pmm_pkg::state_t  st,
	input  pmm_pkg::cfg_t    cfg,
	output pmm_pkg::state_t  nxt,
	output pmm_pkg::result_t res
);
	import pmm_pkg::*;

	logic [1:0]  main_slot;
	logic [1:0]  want;
	logic [1:0]  other;
	logic [2:0]  pon;
	logic [2:0]  poff;
	logic [1:0]  exp_cmd;
	logic [1:0]  radio;
	logic [27:0] dur;
	logic        err;
	logic        changed;

	assign main_slot = (cfg.main_collector_select == COL_FIRST ||
		cfg.main_collector_select == COL_SECOND) ? cfg.main_collector_select : COL_NONE;
	assign want  = (ev.argument == PL_COLLECTOR1) ? COL_FIRST : COL_SECOND;
	assign other = (want == COL_FIRST) ? COL_SECOND : COL_FIRST;

	always_comb begin
		nxt     = st;
		pon     = 3'b000;
		poff    = 3'b000;
		exp_cmd = EXP_CMD_NONE;
		radio   = RADIO_NONE;
		dur     = '0;
		err     = 1'b0;
		changed = 1'b0;
		unique case (ev.action)
			ACT_ENTER_REGION: begin
				nxt.in_region = 1'b1;
				if (!cfg.manual_override && main_slot != COL_NONE &&
					st.active_collector != main_slot) begin
					if (st.collector_on) begin
						poff = poff | slot_bit(st.active_collector);
					end
					nxt.active_collector = main_slot;
					nxt.collector_on = 1'b1;
					pon = pon | slot_bit(main_slot);
					if (!st.hibernating) begin
						nxt.current_mode = MODE_NORMAL;
						changed = 1'b1;
					end
				end
			end
			ACT_LEAVE_REGION: begin
				nxt.in_region = 1'b0;
				if (!cfg.manual_override) begin
					if (st.collector_on && st.active_collector != COL_NONE) begin
						poff = poff | slot_bit(st.active_collector);
						nxt.active_collector = COL_NONE;
						nxt.collector_on = 1'b0;
					end
					if (EXPERIMENT_PRESENT) begin
						if (!st.experiment_on) begin
							nxt.experiment_on = 1'b1;
							pon = pon | PWR_EXPERIMENT;
							exp_cmd = EXP_CMD_START;
							if (!st.hibernating) begin
								nxt.current_mode = MODE_NORMAL;
								changed = 1'b1;
							end
						end
					end else if (!st.hibernating) begin
						nxt.current_mode = MODE_STANDBY;
						changed = 1'b1;
					end
				end
			end
			ACT_EXP_FINISHED: begin
				if (!EXPERIMENT_PRESENT) begin
					err = 1'b1;
				end else if (!cfg.manual_override && st.experiment_on) begin
					nxt.experiment_on = 1'b0;
					poff = poff | PWR_EXPERIMENT;
					if (!st.hibernating) begin
						nxt.current_mode = MODE_STANDBY;
						changed = 1'b1;
					end
				end
			end
			ACT_MODE_REQUEST: begin
				unique case (ev.argument)
					REQ_NORMAL: begin
						if (st.hibernating) begin
							radio = RADIO_ENABLE;
							if (ev.radio_enable_ok) begin
								nxt.hibernating = 1'b0;
							end else begin
								err = 1'b1;
							end
						end
						if (!err && st.active_collector == COL_NONE) begin
							if (main_slot != COL_NONE) begin
								nxt.active_collector = main_slot;
								nxt.collector_on = 1'b1;
								pon = pon | slot_bit(main_slot);
							end else begin
								err = 1'b1;
							end
						end
						if (!err) begin
							nxt.current_mode = MODE_NORMAL;
							changed = 1'b1;
						end
					end
					REQ_HIBERNATE: begin
						nxt.hibernating = 1'b1;
						dur = 28'(ev.hibernation_hours) * SECONDS_PER_HOUR;
						nxt.current_mode = MODE_HIBERNATION;
						changed = 1'b1;
						radio = RADIO_DISABLE;
					end
					REQ_STANDBY: begin
						if (st.active_collector != COL_NONE) begin
							poff = poff | slot_bit(st.active_collector);
							nxt.active_collector = COL_NONE;
							nxt.collector_on = 1'b0;
						end
						if (st.experiment_on) begin
							poff = poff | PWR_EXPERIMENT;
							nxt.experiment_on = 1'b0;
						end
						nxt.current_mode = MODE_STANDBY;
						changed = 1'b1;
					end
					REQ_WAKE: begin
						nxt.hibernating = 1'b0;
						nxt.current_mode = (st.in_region || st.experiment_on) ?
							MODE_NORMAL : MODE_STANDBY;
						changed = 1'b1;
						radio = RADIO_ENABLE;
					end
					default: begin
						err = 1'b1;
					end
				endcase
			end
			ACT_ACTIVATE: begin
				if (ev.argument == PL_COLLECTOR1 || ev.argument == PL_COLLECTOR2) begin
					if (st.active_collector == other) begin
						poff = poff | slot_bit(other);
					end
					nxt.active_collector = want;
					nxt.collector_on = 1'b1;
					pon = pon | slot_bit(want);
					if (!st.hibernating) begin
						nxt.current_mode = MODE_NORMAL;
						changed = 1'b1;
					end
				end else if (ev.argument == PL_EXPERIMENT && EXPERIMENT_PRESENT) begin
					if (!st.experiment_on) begin
						nxt.experiment_on = 1'b1;
						pon = pon | PWR_EXPERIMENT;
						exp_cmd = EXP_CMD_START;
						if (!st.hibernating) begin
							nxt.current_mode = MODE_NORMAL;
							changed = 1'b1;
						end
					end
				end else begin
					err = 1'b1;
				end
			end
			ACT_DEACTIVATE: begin
				if (ev.argument == PL_COLLECTOR1 || ev.argument == PL_COLLECTOR2) begin
					if (st.active_collector == want) begin
						nxt.active_collector = COL_NONE;
						nxt.collector_on = 1'b0;
						poff = poff | slot_bit(want);
						if (st.current_mode == MODE_NORMAL && !st.experiment_on) begin
							nxt.current_mode = MODE_STANDBY;
							changed = 1'b1;
						end
					end
				end else if (ev.argument == PL_EXPERIMENT && EXPERIMENT_PRESENT) begin
					if (st.experiment_on) begin
						nxt.experiment_on = 1'b0;
						exp_cmd = EXP_CMD_CANCEL;
						poff = poff | PWR_EXPERIMENT;
						if (st.current_mode == MODE_NORMAL &&
							st.active_collector == COL_NONE) begin
							nxt.current_mode = MODE_STANDBY;
							changed = 1'b1;
						end
					end
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	always_comb begin
		res.mode               = nxt.current_mode;
		res.mode_changed       = changed;
		res.collector_slot     = nxt.active_collector;
		res.collector_active   = nxt.collector_on;
		res.experiment_active  = nxt.experiment_on;
		res.power_on_mask      = pon;
		res.power_off_mask     = poff;
		res.experiment_command = exp_cmd;
		res.radio_command      = radio;
		res.duration_seconds   = dur;
		res.error              = err;
	end

endmodule
`default_nettype wire

// File: rtl/payload_mode_manager.sv
// Top level of the payload mode manager: input stage, state, result stage and configuration.
`default_nettype none
// Each accepted event beat gives exactly one result beat. A beat is held in an input
// register, decoded against the mode state, and written to an output register, so a
// new event can be taken every cycle unless the output stalls; the result is offered
// from the output register, and a stalled output holds both stages. The two configuration
// registers are written through cfg_write_en, cfg_index and cfg_data and should only be
// changed while no event is in flight.
module payload_mode_manager (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  pmm_pkg::event_t    in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output pmm_pkg::result_t   out_data,
	input  wire                cfg_write_en,
	input  wire [0:0]          cfg_index,
	input  wire [1:0]          cfg_data
);
	import pmm_pkg::*;

	logic    valid_s1;
	event_t  event_s1;
	logic    valid_s2;
	result_t result_s2;
	state_t  state_q;
	cfg_t    cfg_q;
	state_t  state_nxt;
	result_t result_nxt;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	pmm_core u_core (
		.ev  (event_s1),
		.st  (state_q),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.res (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.current_mode     <= MODE_STANDBY;
			state_q.hibernating      <= 1'b0;
			state_q.in_region        <= 1'b0;
			state_q.active_collector <= COL_NONE;
			state_q.collector_on     <= 1'b0;
			state_q.experiment_on    <= 1'b0;
			cfg_q.main_collector_select <= COL_FIRST;
			cfg_q.manual_override       <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_MAIN_COLLECTOR: begin
						cfg_q.main_collector_select <= cfg_data;
					end
					REG_MANUAL_OVERRIDE: begin
						cfg_q.manual_override <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			event_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

`ifndef NO_ASSERTIONS
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("Decoded beat did not reach the output register.");

	a_collector_flag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.collector_on == (state_q.active_collector != COL_NONE))
		else $error("Collector flag disagrees with the active slot.");

	a_duration_only_hibernate: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.duration_seconds != '0 |->
			result_s2.mode == MODE_HIBERNATION && result_s2.mode_changed)
		else $error("Hibernation duration given outside a hibernate request.");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(event_s1))
		else $error("Stalled input beat was lost or changed.");
`endif

endmodule
`default_nettype wire
